// ===== rtl/core/integer_to_padded_ascii_defines.svh =====
`ifndef INTEGER_TO_PADDED_ASCII_DEFINES_SVH
`define INTEGER_TO_PADDED_ASCII_DEFINES_SVH

// Assertion that is checked only outside reset.
`define ITPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define ITPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/itpa_pkg.sv =====
`timescale 1ns / 1ps

package itpa_pkg;

  // Width of the value being converted.
  localparam int unsigned VAL_W = 32;
  // Quotient bits that the divider resolves per cycle, and division steps per digit.
  localparam int unsigned STEP_BITS = 8;
  localparam int unsigned DIV_STEPS = VAL_W / STEP_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned DIGIT_DEPTH_DEF = 32;

  // At most this many characters leave per conversion.
  localparam int unsigned MAX_OUT = 64;
  localparam int unsigned POS_W = $clog2(MAX_OUT);

  // Bit positions inside flag_bits.
  localparam int unsigned F_ZERO   = 0;
  localparam int unsigned F_SIGNED = 1;
  localparam int unsigned F_PLUS   = 2;
  localparam int unsigned F_SPACE  = 3;
  localparam int unsigned F_LEFT   = 4;
  localparam int unsigned F_LOWER  = 5;
  localparam int unsigned F_PREFIX = 6;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LOWER = 8'h20;

  localparam logic [7:0] SYMBOLS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [4:0]       radix;
    logic [6:0]       min_width;
    logic [5:0]       min_digits;
    logic [6:0]       flag_bits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [4:0]       radix;
  } div_in_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
    logic [3:0]       rem;
  } div_out_t;

endpackage

// ===== rtl/core/itpa_divider.sv =====
`timescale 1ns / 1ps

// Divides a value by a small radix, a fixed number of quotient bits per cycle.
module itpa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itpa_pkg::div_in_t  div_i,
  output itpa_pkg::div_out_t div_o
);

  logic [itpa_pkg::VAL_W-1:0]     work_q;
  logic [4:0]                     rem_q;
  logic [4:0]                     radix_q;
  logic [itpa_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  logic [itpa_pkg::VAL_W-1:0] work_d;
  logic [4:0]                 rem_d;

  // Restoring division: the remainder stays below the radix, so it is narrow.
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    for (int i = 0; i < int'(itpa_pkg::STEP_BITS); i++) begin
      rem_d  = {rem_d[3:0], work_d[itpa_pkg::VAL_W-1]};
      work_d = {work_d[itpa_pkg::VAL_W-2:0], 1'b0};
      if (rem_d >= radix_q) begin
        rem_d     = rem_d - radix_q;
        work_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (div_i.start) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == itpa_pkg::DIV_CNT_W'(itpa_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_i.start) begin
      work_q  <= div_i.dividend;
      rem_q   <= '0;
      radix_q <= div_i.radix;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign div_o.done = done_q;
  assign div_o.quot = work_q;
  assign div_o.rem  = rem_q[3:0];

endmodule

// ===== rtl/core/integer_to_padded_ascii.sv =====
`timescale 1ns / 1ps

// Formats one integer as printf-style text and sends it out one ASCII character
// per output word, with last_char set on the final character. An input word
// carries the value, a radix of 2 to 16, a minimum field width, a minimum digit
// count and the flags (zero pad, signed, plus, space, left, lowercase, prefix);
// a word with a radix outside 2..16 is taken and produces no output. Digits come
// from a single divider that resolves 8 quotient bits per cycle; each digit is
// pushed onto a stack when its division is done, and the next division starts
// in that same cycle. After the last digit the field is sized in the states
// ST_SIZE and ST_BOUND, the characters then leave one per cycle while the output
// does not stall, and the next word is taken in the cycle after the last
// character (a 32-bit decimal value has at most 10 digits, a binary one 32).
// At most 64 characters are sent; longer text is cut there and the 64th
// character carries last_char. The output word sits in a register, so the last
// character may still wait on the output while the next input word is taken.
module integer_to_padded_ascii #(
  parameter int unsigned DIGIT_DEPTH = itpa_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itpa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itpa_pkg::out_word_t out_word_o
);

  localparam int unsigned DC_W = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned B_W  = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIZE,
    ST_BOUND,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic                      out_valid_q;
  itpa_pkg::out_word_t       out_word_q;
  logic [DC_W-1:0]           dc_q;
  logic [itpa_pkg::POS_W-1:0] pos_q;

  // Per-conversion settings, captured when the word is taken.
  logic [6:0] width_q;
  logic [5:0] prec_q;
  logic       lower_q;
  logic       left_q;
  logic       zero_q;
  logic [7:0] sign_char_q;
  logic       sign_len_q;
  logic [1:0] pfx_len_q;
  logic [4:0] radix_q;

  // Digit stack: the most recent digit, the most significant one, sits on top.
  logic [3:0] stack_q [DIGIT_DEPTH];

  // Sizes and segment boundaries of the text.
  logic [B_W-1:0] pad_q;
  logic [B_W-1:0] extra_q;
  logic [B_W-1:0] b_lpad_q, b_sign_q, b_pfx_q, b_prec_q, b_dig_q, total_q;

  itpa_pkg::div_in_t  div_in;
  itpa_pkg::div_out_t div_out;

  logic                       in_acc;
  logic                       radix_ok;
  logic                       neg;
  logic [itpa_pkg::VAL_W-1:0] mag;
  logic [7:0]                 sign_char;
  logic [1:0]                 pfx_len;
  logic                       more_digits;
  logic                       out_free;

  logic [B_W-1:0] prec_eff;
  logic [B_W-1:0] used_len;
  logic [B_W-1:0] width_ext;
  logic [B_W-1:0] pos_ext;
  logic [7:0]     emit_char;
  logic           emit_last;
  logic           emit_digit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign radix_ok   = (in_word_i.radix >= itpa_pkg::RADIX_MIN) &&
                      (in_word_i.radix <= itpa_pkg::RADIX_MAX);

  // Sign handling: a negative signed value prints as its magnitude.
  assign neg = in_word_i.flag_bits[itpa_pkg::F_SIGNED] &&
               in_word_i.value[itpa_pkg::VAL_W-1];
  assign mag = neg ? (~in_word_i.value + 1'b1) : in_word_i.value;

  always_comb begin
    sign_char = '0;
    if (in_word_i.flag_bits[itpa_pkg::F_SIGNED]) begin
      if (neg) begin
        sign_char = itpa_pkg::CH_MINUS;
      end else if (in_word_i.flag_bits[itpa_pkg::F_PLUS]) begin
        sign_char = itpa_pkg::CH_PLUS;
      end else if (in_word_i.flag_bits[itpa_pkg::F_SPACE]) begin
        sign_char = itpa_pkg::CH_SPACE;
      end
    end
    pfx_len = 2'd0;
    if (in_word_i.flag_bits[itpa_pkg::F_PREFIX]) begin
      if (in_word_i.radix == itpa_pkg::RADIX_HEX) begin
        pfx_len = 2'd2;
      end else if (in_word_i.radix == itpa_pkg::RADIX_OCT) begin
        pfx_len = 2'd1;
      end
    end
  end

  // Another division follows while the quotient is nonzero and the stack has room.
  assign more_digits = (div_out.quot != '0) && (dc_q < DC_W'(DIGIT_DEPTH - 1));

  assign div_in.start    = (in_acc && radix_ok) ||
                           ((state_q == ST_DIVIDE) && div_out.done && more_digits);
  assign div_in.dividend = (state_q == ST_IDLE) ? mag : div_out.quot;
  assign div_in.radix    = (state_q == ST_IDLE) ? in_word_i.radix : radix_q;

  itpa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_in),
    .div_o  (div_out)
  );

  // Field sizing: the digit field is at least the digit count, the rest is pad.
  assign prec_eff  = (B_W'(prec_q) > B_W'(dc_q)) ? B_W'(prec_q) : B_W'(dc_q);
  assign used_len  = B_W'(sign_len_q) + B_W'(pfx_len_q) + prec_eff;
  assign width_ext = B_W'(width_q);

  // The character at the current position follows from the segment boundaries.
  assign pos_ext  = B_W'(pos_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    emit_digit = 1'b0;
    if (pos_ext < b_lpad_q) begin
      emit_char = itpa_pkg::CH_SPACE;
    end else if (pos_ext < b_sign_q) begin
      emit_char = sign_char_q;
    end else if (pos_ext < b_pfx_q) begin
      emit_char = (pos_ext == b_sign_q) ? itpa_pkg::CH_ZERO
                                        : (itpa_pkg::CH_X | (lower_q ? itpa_pkg::CH_LOWER : '0));
    end else if (pos_ext < b_prec_q) begin
      emit_char = itpa_pkg::CH_ZERO;
    end else if (pos_ext < b_dig_q) begin
      emit_char  = itpa_pkg::SYMBOLS[stack_q[0]] | (lower_q ? itpa_pkg::CH_LOWER : '0);
      emit_digit = 1'b1;
    end else begin
      emit_char = itpa_pkg::CH_SPACE;
    end
    emit_last = (pos_ext == total_q - 1'b1) ||
                (pos_q == itpa_pkg::POS_W'(itpa_pkg::MAX_OUT - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      dc_q        <= '0;
      pos_q       <= '0;
    end else begin
      // In the emit state a new character enters the output register whenever it is free;
      // otherwise a taken word leaves it.
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          dc_q  <= '0;
          pos_q <= '0;
          if (in_acc && radix_ok) begin
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_out.done) begin
            dc_q <= dc_q + 1'b1;
            if (!more_digits) begin
              state_q <= ST_SIZE;
            end
          end
        end
        ST_SIZE: begin
          state_q <= ST_BOUND;
        end
        ST_BOUND: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_word_q.out_char  <= emit_char;
            out_word_q.last_char <= emit_last;
            if (emit_last) begin
              state_q <= ST_IDLE;
            end else begin
              pos_q <= pos_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      width_q     <= in_word_i.min_width;
      prec_q      <= in_word_i.min_digits;
      lower_q     <= in_word_i.flag_bits[itpa_pkg::F_LOWER];
      left_q      <= in_word_i.flag_bits[itpa_pkg::F_LEFT];
      zero_q      <= in_word_i.flag_bits[itpa_pkg::F_ZERO] &&
                     !in_word_i.flag_bits[itpa_pkg::F_LEFT];
      sign_char_q <= sign_char;
      sign_len_q  <= (sign_char != '0);
      pfx_len_q   <= pfx_len;
      radix_q     <= in_word_i.radix;
    end

    if ((state_q == ST_DIVIDE) && div_out.done) begin
      for (int i = int'(DIGIT_DEPTH) - 1; i > 0; i--) begin
        stack_q[i] <= stack_q[i-1];
      end
      stack_q[0] <= div_out.rem;
    end else if ((state_q == ST_EMIT) && out_free && emit_digit) begin
      for (int i = 0; i < int'(DIGIT_DEPTH) - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
      stack_q[DIGIT_DEPTH-1] <= '0;
    end

    if (state_q == ST_SIZE) begin
      extra_q <= prec_eff - B_W'(dc_q);
      pad_q   <= (width_ext > used_len) ? (width_ext - used_len) : '0;
    end

    // Pad lands on the left as spaces, after the prefix as zeros, or on the right.
    // The zero pad and the precision zeros both emit '0', so they share one segment.
    if (state_q == ST_BOUND) begin
      b_lpad_q <= (!zero_q && !left_q) ? pad_q : '0;
      b_sign_q <= ((!zero_q && !left_q) ? pad_q : '0) + B_W'(sign_len_q);
      b_pfx_q  <= ((!zero_q && !left_q) ? pad_q : '0) + B_W'(sign_len_q) + B_W'(pfx_len_q);
      b_prec_q <= pad_q + B_W'(sign_len_q) + B_W'(pfx_len_q) - (left_q ? pad_q : '0) +
                  extra_q;
      b_dig_q  <= pad_q + B_W'(sign_len_q) + B_W'(pfx_len_q) - (left_q ? pad_q : '0) +
                  extra_q + B_W'(dc_q);
      total_q  <= pad_q + B_W'(sign_len_q) + B_W'(pfx_len_q) + extra_q + B_W'(dc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/core/itpa_checker.sv =====
`timescale 1ns / 1ps
`include "integer_to_padded_ascii_defines.svh"

// Port-level checks for the integer formatter.
module itpa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input itpa_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input itpa_pkg::out_word_t out_word_o
);

  `ITPA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "stalled output word changed")
  `ITPA_ASSERT(a_busy_after_take, in_valid_i && !in_stall_o && in_word_i.radix >= itpa_pkg::RADIX_MIN && in_word_i.radix <= itpa_pkg::RADIX_MAX |=> in_stall_o, "input not stalled during conversion")
  `ITPA_ASSERT(a_idle_no_output, !in_stall_o && !out_valid_o |=> !out_valid_o, "output word appeared while idle")
  `ITPA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind integer_to_padded_ascii itpa_checker u_itpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
